// File: rtl/core/tfs_pkg.sv
// Shared types, constants and row table for the three-of-five share joiner.
package tfs_pkg;

  localparam int SHARES          = 5;
  localparam int ROWS            = 10;
  localparam int ROW_W           = 4;
  localparam int SIZE_W          = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_PRESENT    = 3'd0;
  localparam logic [2:0] REG_SIZE_ONE   = 3'd1;
  localparam logic [2:0] REG_SIZE_TWO   = 3'd2;
  localparam logic [2:0] REG_SIZE_THREE = 3'd3;
  localparam logic [2:0] REG_SIZE_FOUR  = 3'd4;
  localparam logic [2:0] REG_SIZE_FIVE  = 3'd5;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_END   = 2'd1,
    ST_COVER = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] head_one;
    logic [7:0] head_two;
    logic [7:0] head_three;
    logic [7:0] head_four;
    logic [7:0] head_five;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [4:0]  pop_mask;
    logic [1:0]  status;
  } out_item_t;

  // what the merge stage decides for one position
  typedef struct packed {
    logic [7:0]        out_byte;
    logic [SHARES-1:0] pop_mask;
    status_t           status;
    logic              advance;
    logic              finish;
  } merge_res_t;

  // member set of each row; members are ascending, so the lowest
  // present bit is the first present member
  function automatic logic [SHARES-1:0] row_mask(input logic [ROW_W-1:0] row);
    logic [SHARES-1:0] m;
    unique case (row)
      4'd0:    m = 5'b00111;
      4'd1:    m = 5'b01011;
      4'd2:    m = 5'b10011;
      4'd3:    m = 5'b01101;
      4'd4:    m = 5'b10101;
      4'd5:    m = 5'b11001;
      4'd6:    m = 5'b01110;
      4'd7:    m = 5'b10110;
      4'd8:    m = 5'b11010;
      4'd9:    m = 5'b11100;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/three_of_five_share_joiner_core.sv
// Top level of the three-of-five share joiner: config port, lanes, merge, output register.
//
// Usage:
//   item channel   : item_valid / item_ready / item carry the five current head
//                    bytes, one per share stream.
//   result channel : result_valid / result_ready / result carry out_byte,
//                    pop_mask (heads consumed by this transfer) and status
//                    (byte, end of data, cannot cover).
//   config port    : APB-style, pready always high. 0x00 present_mask,
//                    0x04..0x14 size of shares one..five. Write only while idle.
// Output: a result is registered at its item transfer and shown in the next cycle.
// Throughput: one item per cycle unless result_ready stalls the output register.
//   The rate is set by the loop from the lane counters through the size compare
//   and the merge select back into the counter increment.
// Stall: the output register holds while result_ready is low; item_ready
//   follows "output register empty or being taken", so a new item is taken
//   in the same cycle the held result leaves.
// Reset (rst, synchronous): row back to zero, consumed counts cleared,
//   finished cleared, config registers zeroed, result register emptied.
// Once end of data is reported the block keeps answering end until reset.
module three_of_five_share_joiner_core
  import tfs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_ready,
  input  in_item_t          item,
  // result channel
  output logic              result_valid,
  input  logic              result_ready,
  output out_item_t         result,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // config registers
  logic [SHARES-1:0] present_mask;
  logic [SIZE_W-1:0] share_size [SHARES];

  // position state
  logic [ROW_W-1:0]  row_index;
  logic              finished;

  logic [SHARES-1:0] has_bytes;
  merge_res_t        res;
  logic              accept;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask <= '0;
      for (int i = 0; i < SHARES; i++) share_size[i] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PRESENT:    present_mask  <= pwdata[SHARES-1:0];
        REG_SIZE_ONE:   share_size[0] <= pwdata[SIZE_W-1:0];
        REG_SIZE_TWO:   share_size[1] <= pwdata[SIZE_W-1:0];
        REG_SIZE_THREE: share_size[2] <= pwdata[SIZE_W-1:0];
        REG_SIZE_FOUR:  share_size[3] <= pwdata[SIZE_W-1:0];
        REG_SIZE_FIVE:  share_size[4] <= pwdata[SIZE_W-1:0];
        default: ;  // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESENT:    prdata = DATA_W'(present_mask);
      REG_SIZE_ONE:   prdata = DATA_W'(share_size[0]);
      REG_SIZE_TWO:   prdata = DATA_W'(share_size[1]);
      REG_SIZE_THREE: prdata = DATA_W'(share_size[2]);
      REG_SIZE_FOUR:  prdata = DATA_W'(share_size[3]);
      REG_SIZE_FIVE:  prdata = DATA_W'(share_size[4]);
      default:        prdata = '0;
    endcase
  end

  // handshake: take a new item whenever the output register frees up
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // one lane per share
  for (genvar g = 0; g < SHARES; g++) begin : g_lane
    tfs_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .size      (share_size[g]),
      .pop       (accept && res.pop_mask[g]),
      .has_bytes (has_bytes[g])
    );
  end

  tfs_merge u_merge (
    .row       (row_index),
    .present   (present_mask),
    .has_bytes (has_bytes),
    .finished  (finished),
    .heads     (item),
    .res       (res)
  );

  // row rotation and sticky end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      finished  <= 1'b0;
    end else if (accept) begin
      if (res.advance) begin
        row_index <= (row_index == ROW_W'(ROWS - 1)) ? '0 : row_index + ROW_W'(1);
      end
      if (res.finish) finished <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_ready) begin
      result_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.out_byte <= res.out_byte;
      result.pop_mask <= res.pop_mask;
      result.status   <= res.status;
    end
  end

endmodule

// File: rtl/core/tfs_lane.sv
// One share lane: consumed counter and remaining-bytes compare.
module tfs_lane
  import tfs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] size,
  input  logic              pop,
  output logic              has_bytes
);

  localparam int CMP_W = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;

  logic [COUNT_WIDTH-1:0] count;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       size_ext;

  assign count_ext = CMP_W'(count);
  assign size_ext  = CMP_W'(size);
  assign has_bytes = count_ext < size_ext;

  // saturating count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (pop && (count != {COUNT_WIDTH{1'b1}})) begin
      count <= count + COUNT_WIDTH'(1);
    end
  end

endmodule

// File: rtl/core/tfs_merge.sv
// Merge stage: picks the share for the current row and builds the result.
module tfs_merge
  import tfs_pkg::*;
(
  input  logic [ROW_W-1:0]  row,
  input  logic [SHARES-1:0] present,
  input  logic [SHARES-1:0] has_bytes,
  input  logic              finished,
  input  in_item_t          heads,
  output merge_res_t        res
);

  logic [7:0]        head [SHARES];
  logic [SHARES-1:0] cand;
  logic [SHARES-1:0] chosen;
  logic [2:0]        n_present;
  logic [7:0]        sel_byte;

  assign head[0] = heads.head_one;
  assign head[1] = heads.head_two;
  assign head[2] = heads.head_three;
  assign head[3] = heads.head_four;
  assign head[4] = heads.head_five;

  assign cand   = row_mask(row) & present;
  assign chosen = cand & (~cand + SHARES'(1));  // lowest set bit

  always_comb begin
    n_present = '0;
    sel_byte  = '0;
    for (int i = 0; i < SHARES; i++) begin
      n_present = n_present + 3'(present[i]);
      sel_byte  = sel_byte | (head[i] & {8{chosen[i]}});
    end
  end

  always_comb begin
    res = '{out_byte: '0, pop_mask: '0, status: ST_BYTE, advance: 1'b0, finish: 1'b0};
    priority if (finished) begin
      res.status = ST_END;
    end else if (n_present < 3'd3) begin
      res.status = ST_COVER;
    end else if ((chosen & has_bytes) == '0) begin
      res.status = ST_END;
      res.finish = 1'b1;
    end else begin
      res.out_byte = sel_byte;
      res.pop_mask = cand & has_bytes;
      res.advance  = 1'b1;
    end
  end

endmodule

// File: rtl/core/tfs_checker.sv
// Port-level checker for the share joiner, bound to the top level.
module tfs_checker
  import tfs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // non-byte results carry nothing
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_BYTE) |->
      (result.pop_mask == '0) && (result.out_byte == '0))
    else $error("end or cover result with payload");

  // a byte pops between one and three heads
  a_pops: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_BYTE) |->
      ($countones(result.pop_mask) >= 1) && ($countones(result.pop_mask) <= 3))
    else $error("bad pop count");

  // intake is never blocked while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item refused with empty output");

endmodule

bind three_of_five_share_joiner_core tfs_checker u_tfs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: verif/tfs_join_checker.sv
// Scoreboard for the share joiner: tracks config writes, predicts each result, compares.
module tfs_join_checker
  import tfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  in_item_t          item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // bit i set when share i belongs to the row
  localparam logic [SHARES-1:0] ROW_SET [ROWS] = '{
    5'b00111, 5'b01011, 5'b10011, 5'b01101, 5'b10101,
    5'b11001, 5'b01110, 5'b10110, 5'b11010, 5'b11100
  };

  logic [SHARES-1:0]          mask_q;
  logic [SIZE_W-1:0]          size_q [SHARES];
  logic [COUNT_WIDTH_DEF-1:0] count_q [SHARES];
  logic [ROW_W-1:0]           row_q;
  logic                       done_q;
  out_item_t                  want_q [$];
  int                         mismatches;

  // one output position: what the joiner should emit for these heads
  function automatic out_item_t join_position(input in_item_t heads);
    out_item_t         r;
    logic [7:0]        lane_byte [SHARES];
    logic [SHARES-1:0] members;
    int                chosen;
    r = '0;
    lane_byte[0] = heads.head_one;
    lane_byte[1] = heads.head_two;
    lane_byte[2] = heads.head_three;
    lane_byte[3] = heads.head_four;
    lane_byte[4] = heads.head_five;
    if (done_q) begin
      r.status = ST_END;
      return r;
    end
    if ($countones(mask_q) < 3) begin
      r.status = ST_COVER;
      return r;
    end
    members = ROW_SET[row_q] & mask_q;
    chosen = -1;
    for (int i = SHARES - 1; i >= 0; i--)
      if (members[i]) chosen = i;
    if (chosen < 0 || count_q[chosen] >= size_q[chosen]) begin
      done_q = 1'b1;
      r.status = ST_END;
      return r;
    end
    r.out_byte = lane_byte[chosen];
    // availability is judged per share on counts before this position
    for (int i = 0; i < SHARES; i++) begin
      if (members[i] && (i == chosen || count_q[i] < size_q[i])) begin
        r.pop_mask[i] = 1'b1;
        if (count_q[i] != '1) count_q[i] = count_q[i] + 1'b1;
      end
    end
    r.status = ST_BYTE;
    row_q = (row_q == ROWS - 1) ? '0 : row_q + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t          want;
    logic [ADDR_W-3:0]  idx;
    if (rst) begin
      mask_q = '0;
      row_q  = '0;
      done_q = 1'b0;
      for (int i = 0; i < SHARES; i++) begin
        size_q[i]  = '0;
        count_q[i] = '0;
      end
      want_q.delete();
    end else begin
      // older expectation first, then the transfer that lands on this edge
      if (result_valid && result_ready) begin
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result byte %h pop %b status %0d",
                     $time, result.out_byte, result.pop_mask, result.status);
        end else begin
          want = want_q.pop_front();
          if (result.out_byte !== want.out_byte || result.pop_mask !== want.pop_mask ||
              result.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected byte %h pop %b status %0d, got byte %h pop %b status %0d",
                       $time, want.out_byte, want.pop_mask, want.status,
                       result.out_byte, result.pop_mask, result.status);
          end
        end
      end
      if (item_valid && item_ready) want_q.push_back(join_position(item));
      if (psel && penable && pwrite && pready) begin
        idx = paddr[ADDR_W-1:2];
        case (idx)
          REG_PRESENT: mask_q = pwdata[SHARES-1:0];
          REG_SIZE_ONE, REG_SIZE_TWO, REG_SIZE_THREE, REG_SIZE_FOUR, REG_SIZE_FIVE:
            size_q[idx - REG_SIZE_ONE] = pwdata[SIZE_W-1:0];
          default: ;  // hole in the map
        endcase
      end
    end
    fail_count <= mismatches;
    open_count <= want_q.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the share joiner testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tfs_pkg::*;

  localparam int         ITEM_GOAL    = 550;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 150;
  // addresses past the last register, writes there must be dropped
  localparam logic [2:0] REG_SPARE    = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  in_item_t          item;
  logic              result_valid;
  logic              result_ready;
  out_item_t         result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                open_count;

  // idling knobs, percent of cycles
  int send_gap_pct;
  int recv_stall_pct;
  bit hold_req;
  int cycles;
  // heads taken per share so far, seen on the result channel
  int pops [SHARES];

  three_of_five_share_joiner_core dut (.*);
  tfs_join_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && result_valid && result_ready)
      for (int i = 0; i < SHARES; i++) pops[i] <= pops[i] + result.pop_mask[i];

  // receiver: random stalls, plus one long hold-off on request so the
  // output register stays full and the block pushes back on the sender
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // setup and access phase, then an idle gap so writes never abut
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one transfer on the item channel; valid stays up until taken
  task automatic send_item(input in_item_t heads);
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= heads;
    do @(posedge clk); while (!item_ready);
  endtask

  // drain: every expected result back, then idle before returning
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic in_item_t rand_heads();
    return in_item_t'({$urandom, 8'($urandom)});
  endfunction

  // New present set and sizes. Any share that can be first in a row keeps
  // a size far above anything it will consume, so the stream never ends
  // early. With all five present, shares four and five are never first,
  // so they get either a small or a fully random size and may run dry mid-stream.
  task automatic random_config();
    logic [SHARES-1:0] mask;
    logic [31:0]       sz;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 20) mask = '1;
    else if (pick < 85) do mask = SHARES'($urandom_range(31)); while ($countones(mask) < 3);
    else do mask = SHARES'($urandom_range(31)); while ($countones(mask) >= 3);
    reg_write(REG_PRESENT, 32'(mask));
    for (int i = 0; i < SHARES; i++) begin
      if (mask == '1 && i >= 3) sz = $urandom_range(1) ? $urandom_range(700) : $urandom;
      else if (mask[i]) sz = {1'b1, 31'($urandom)};
      else sz = $urandom;
      reg_write(3'(REG_SIZE_ONE + i), sz);
    end
  endtask

  initial begin
    int sent;
    int seg_len;
    bit held;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // no share present: coverage error; every size at its top value
    reg_write(REG_PRESENT, 32'h0);
    for (int k = 0; k < SHARES; k++) reg_write(3'(REG_SIZE_ONE + k), 32'hFFFF_FFFF);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h0);
    send_item('0);
    settle();
    // two shares cannot cover either
    reg_write(REG_PRESENT, 32'h03);
    send_item('1);
    settle();
    // all present, share five empty: it is never first in a row, so it
    // just drops out of the pop mask; one full lap of the rows
    reg_write(REG_PRESENT, 32'h1F);
    reg_write(REG_SIZE_FIVE, 32'h0);
    for (int k = 0; k < ROWS; k++) begin
      if (k % 3 == 0) send_item('1);
      else if (k % 3 == 1) send_item('0);
      else send_item(rand_heads());
    end
    settle();
    // exactly three present, two different sets
    reg_write(REG_SIZE_FIVE, 32'hFFFF_FFFF);
    reg_write(REG_PRESENT, 32'h07);
    repeat (3) send_item(rand_heads());
    settle();
    reg_write(REG_PRESENT, 32'h1A);
    repeat (3) send_item(rand_heads());
    settle();

    // --- random, four idling phases ---
    sent = 0;
    held = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_gap_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      while (sent < (phase + 1) * ITEM_GOAL / 4) begin
        random_config();
        // long receiver hold-off once, while the sender keeps pushing
        if (phase == 0 && !held) begin
          hold_req = 1'b1;
          held     = 1'b1;
          seg_len  = 40;
        end else begin
          seg_len = $urandom_range(10, 40);
        end
        repeat (seg_len) begin
          send_item(rand_heads());
          sent++;
        end
        settle();
      end
    end

    // --- end of data ---
    // shares three to five only; share five gets one to eight bytes beyond what
    // it has given so far, so it runs dry and the stream ends once it is chosen with none left
    reg_write(REG_PRESENT, 32'h1C);
    reg_write(REG_SIZE_THREE, 32'hFFFF_FFFF);
    reg_write(REG_SIZE_FOUR, 32'hFFFF_FFFF);
    reg_write(REG_SIZE_FIVE, 32'(pops[4] + $urandom_range(1, 8)));
    repeat (40) send_item(rand_heads());
    settle();
    // finished wins over the coverage error
    reg_write(REG_PRESENT, 32'h0);
    repeat (5) send_item(rand_heads());
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
